@@ hw/rtl/linear_interp_rate_converter_top_assert.svh @@
// Assertion macros used by the converter's controller (lirc_ctrl).
// Each macro takes a label, an antecedent and a consequent, all sampled on clk.
`ifndef LINEAR_INTERP_RATE_CONVERTER_TOP_ASSERT_SVH
`define LINEAR_INTERP_RATE_CONVERTER_TOP_ASSERT_SVH
`ifndef SYNTH
`define LIRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lirc assertion failed");
`define LIRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lirc assertion failed");
`else
`define LIRC_ASSERT_IMP(lbl, ante, cons)
`define LIRC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/lirc_pkg.sv @@
package lirc_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SKIP_W     = 16;
  localparam int unsigned COUNT_W    = 24;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // Shared divider: 48-bit dividend, 16-bit divisor, two quotient bits per cycle.
  localparam int unsigned DIV_NUM_W = 48;
  localparam int unsigned DIV_DEN_W = 16;
  localparam int unsigned DIV_STEPS = 2;
  localparam int unsigned DIV_CYC   = DIV_NUM_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_CYC);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_SKIP   = 2'd0,
    REG_OUT_SKIP  = 2'd1,
    REG_IN_COUNT  = 2'd2,
    REG_OUT_LIMIT = 2'd3
  } cfg_reg_t;

  // What the shared divider is working on.
  typedef enum logic [1:0] {
    DIV_LEN  = 2'd0,
    DIV_PROD = 2'd1,
    DIV_PAD  = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     div_start;
    div_sel_t div_sel;
    logic     len_load;
    logic     first_apply;
    logic     pend_load;
    logic     emit;
    logic     emit_last;
    logic     set_finished;
    logic     pad_apply;
    logic     advance;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic no_block;
    logic behind;
    logic more;
    logic len_reached;
    logic div_done;
    logic div_busy;
    logic pend;
    logic slot_free;
  } sts_t;

endpackage

@@ hw/rtl/lirc_div.sv @@
module lirc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [lirc_pkg::DIV_NUM_W-1:0] num,
  input  logic [lirc_pkg::DIV_DEN_W-1:0] den,
  output logic                           busy,
  output logic                           done,
  output logic [lirc_pkg::DIV_NUM_W-1:0] quot,
  output logic [lirc_pkg::DIV_DEN_W-1:0] rmd
);

  localparam int unsigned NW = lirc_pkg::DIV_NUM_W;
  localparam int unsigned DW = lirc_pkg::DIV_DEN_W;

  logic [NW-1:0]                    work;
  logic [DW-1:0]                    part;
  logic [DW-1:0]                    den_q;
  logic [lirc_pkg::DIV_CNT_W-1:0]   cnt;
  logic [NW-1:0]                    step_w;
  logic [DW-1:0]                    step_r;
  logic [DW:0]                      trial;

  // Restoring division: the dividend shifts out at the top while quotient
  // bits shift in at the bottom of the same register.
  always_comb begin
    step_w = work;
    step_r = part;
    trial  = '0;
    for (int i = 0; i < lirc_pkg::DIV_STEPS; i++) begin
      trial  = {step_r, step_w[NW-1]};
      step_w = {step_w[NW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial     = trial - {1'b0, den_q};
        step_w[0] = 1'b1;
      end
      step_r = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == lirc_pkg::DIV_CNT_W'(lirc_pkg::DIV_CYC - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work  <= num;
      part  <= '0;
      den_q <= den;
    end else if (busy) begin
      work <= step_w;
      part <= step_r;
    end
  end

  assign quot = work;
  assign rmd  = part;

endmodule

@@ hw/rtl/lirc_dpath.sv @@
module lirc_dpath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [lirc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lirc_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [lirc_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                                   first,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [lirc_pkg::SAMPLE_W-1:0]   out_sample,
  output logic                                   run_last,
  output logic                                   done_res,
  input  lirc_pkg::cmd_t                         cmd,
  output lirc_pkg::sts_t                         sts
);

  localparam int unsigned SW = lirc_pkg::SAMPLE_W;
  localparam int unsigned KW = lirc_pkg::SKIP_W;
  localparam int unsigned CW = lirc_pkg::COUNT_W;
  localparam int unsigned TW = lirc_pkg::TOTAL_W;
  localparam int unsigned NW = lirc_pkg::DIV_NUM_W;
  localparam int unsigned QW = NW + 2;

  // Configuration registers.
  logic [KW-1:0] in_skip;
  logic [KW-1:0] out_skip;
  logic [CW-1:0] in_count;
  logic [CW-1:0] out_limit;

  // Converter state.
  logic signed [SW-1:0] last_sample;
  logic [TW-1:0]        in_total;
  logic [TW-1:0]        out_total;
  logic [CW-1:0]        out_done;
  logic [CW-1:0]        in_seen;
  logic                 finished;

  // Per-word working registers.
  logic signed [SW-1:0] next_sample;
  logic                 first_flag;
  logic [CW-1:0]        len;
  logic signed [SW-1:0] pend_sample;
  logic                 pend;
  logic                 prod_neg;

  logic [KW-1:0]        isk;
  logic [KW-1:0]        osk;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        lim;
  logic [TW:0]          target;
  logic                 behind;
  logic                 len_reached;
  logic [TW-1:0]        tick_gap;
  logic signed [SW:0]   delta;
  logic [SW:0]          delta_abs;
  logic [NW-1:0]        prod;
  logic [CW+KW-1:0]     len_prod;
  logic [NW-1:0]        div_num;
  logic [KW-1:0]        div_den;
  logic                 div_busy;
  logic                 div_done;
  logic [NW-1:0]        div_quot;
  logic [KW-1:0]        div_rmd;
  logic signed [QW-1:0] q_ext;
  logic signed [QW-1:0] q_val;
  logic signed [QW-1:0] sum;
  logic signed [SW-1:0] sat;
  logic [CW-1:0]        len_val;
  logic [KW-1:0]        pad;
  logic [TW:0]          pad_total;
  logic [CW-1:0]        in_seen_inc;
  logic                 slot_free;

  assign cfg_ready = 1'b1;

  // A zero register acts as one.
  assign isk = (in_skip   == '0) ? KW'(1) : in_skip;
  assign osk = (out_skip  == '0) ? KW'(1) : out_skip;
  assign cnt = (in_count  == '0) ? CW'(1) : in_count;
  assign lim = (out_limit == '0) ? CW'(1) : out_limit;

  assign target      = {1'b0, in_total} + (TW+1)'(isk);
  assign behind      = {1'b0, out_total} < target;
  assign len_reached = out_done >= len;

  assign tick_gap  = (out_total >= in_total) ? out_total - in_total : '0;
  assign delta     = {next_sample[SW-1], next_sample} - {last_sample[SW-1], last_sample};
  assign delta_abs = delta[SW] ? (SW+1)'(-delta) : (SW+1)'(delta);
  assign prod      = NW'(delta_abs[SW-1:0]) * NW'(tick_gap);
  assign len_prod  = (CW+KW)'(cnt) * (CW+KW)'(isk);

  always_comb begin
    case (cmd.div_sel)
      lirc_pkg::DIV_LEN:  div_num = NW'(len_prod);
      lirc_pkg::DIV_PROD: div_num = prod;
      lirc_pkg::DIV_PAD:  div_num = NW'(target - {1'b0, out_total});
      default:            div_num = '0;
    endcase
  end
  assign div_den = (cmd.div_sel == lirc_pkg::DIV_PROD) ? isk : osk;

  lirc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot),
    .rmd   (div_rmd)
  );

  // Interpolated value, truncated toward zero, then clipped to 16 bits.
  assign q_ext = signed'({2'b00, div_quot});
  assign q_val = prod_neg ? -q_ext : q_ext;
  assign sum   = QW'(last_sample) + q_val;
  always_comb begin
    if (sum > QW'(32767)) begin
      sat = 16'sh7FFF;
    end else if (sum < -QW'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[SW-1:0];
    end
  end

  assign len_val     = (div_quot > NW'(lim)) ? lim : div_quot[CW-1:0];
  assign pad         = (div_rmd == '0) ? '0 : osk - div_rmd;
  assign pad_total   = target + (TW+1)'(pad);
  assign in_seen_inc = in_seen + 1'b1;
  assign slot_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_skip   <= KW'(1);
      out_skip  <= KW'(1);
      in_count  <= CW'(1);
      out_limit <= CW'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (lirc_pkg::cfg_reg_t'(cfg_index))
        lirc_pkg::REG_IN_SKIP:   in_skip   <= cfg_data[KW-1:0];
        lirc_pkg::REG_OUT_SKIP:  out_skip  <= cfg_data[KW-1:0];
        lirc_pkg::REG_IN_COUNT:  in_count  <= cfg_data[CW-1:0];
        lirc_pkg::REG_OUT_LIMIT: out_limit <= cfg_data[CW-1:0];
        default:                 in_skip   <= in_skip;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample <= '0;
      in_total    <= '0;
      out_total   <= '0;
      out_done    <= '0;
      in_seen     <= '0;
      finished    <= 1'b0;
      pend        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.first_apply) begin
        last_sample <= next_sample;
        in_total    <= '0;
        out_total   <= TW'(osk);
        out_done    <= CW'(1);
        in_seen     <= CW'(1);
        finished    <= (cnt <= CW'(1)) || (len <= CW'(1));
      end
      if (cmd.pend_load) begin
        out_done  <= out_done + 1'b1;
        out_total <= out_total + TW'(osk);
      end
      if (cmd.set_finished) begin
        finished <= 1'b1;
      end
      if (cmd.pad_apply) begin
        out_total <= pad_total[TW-1:0];
      end
      if (cmd.advance) begin
        last_sample <= next_sample;
        in_seen     <= in_seen_inc;
        if (in_seen_inc >= cnt) begin
          finished <= 1'b1;
        end
        // Both totals restart from zero when they meet.
        if (target[TW-1:0] == out_total) begin
          in_total  <= '0;
          out_total <= '0;
        end else begin
          in_total <= target[TW-1:0];
        end
      end
      if (cmd.first_apply || cmd.pend_load) begin
        pend <= 1'b1;
      end else if (cmd.emit || cmd.load_in) begin
        pend <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      next_sample <= in_sample;
      first_flag  <= first;
    end
    if (cmd.len_load) begin
      len <= len_val;
    end
    if (cmd.div_start && cmd.div_sel == lirc_pkg::DIV_PROD) begin
      prod_neg <= delta[SW];
    end
    if (cmd.first_apply) begin
      pend_sample <= next_sample;
    end else if (cmd.pend_load) begin
      pend_sample <= sat;
    end
    if (cmd.emit) begin
      out_sample <= pend_sample;
      run_last   <= cmd.emit_last;
      done_res   <= cmd.emit_last && finished;
    end
  end

  always_comb begin
    sts.first       = first_flag;
    sts.no_block    = (in_seen == '0) || finished;
    sts.behind      = behind;
    sts.more        = behind && !len_reached;
    sts.len_reached = len_reached;
    sts.div_done    = div_done;
    sts.div_busy    = div_busy;
    sts.pend        = pend;
    sts.slot_free   = slot_free;
  end

endmodule

@@ hw/rtl/lirc_ctrl.sv @@
`include "linear_interp_rate_converter_top_assert.svh"

module lirc_ctrl #(
  parameter int unsigned MAX_RUN = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  lirc_pkg::sts_t sts,
  output lirc_pkg::cmd_t cmd
);

  localparam int unsigned NW = $clog2(MAX_RUN + 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LEN    = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_CHECK  = 8'b0000_1000,
    S_QUOT   = 8'b0001_0000,
    S_PAD    = 8'b0010_0000,
    S_ADV    = 8'b0100_0000,
    S_LAST   = 8'b1000_0000
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [NW-1:0] n;
  logic          loop_go;

  assign in_stall = (state != S_IDLE);
  assign loop_go  = sts.more && (n < NW'(MAX_RUN));

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = lirc_pkg::DIV_LEN;
          state_next    = S_LEN;
        end
      end
      S_LEN: begin
        if (sts.div_done) begin
          cmd.len_load = 1'b1;
          state_next   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.first) begin
          cmd.first_apply = 1'b1;
          state_next      = S_LAST;
        end else if (sts.no_block) begin
          state_next = S_IDLE;
        end else if (sts.behind) begin
          state_next = S_CHECK;
        end else begin
          state_next = S_ADV;
        end
      end
      S_CHECK: begin
        if (loop_go) begin
          if (!sts.pend || sts.slot_free) begin
            cmd.emit      = sts.pend;
            cmd.div_start = 1'b1;
            cmd.div_sel   = lirc_pkg::DIV_PROD;
            state_next    = S_QUOT;
          end
        end else if (sts.len_reached) begin
          cmd.set_finished = 1'b1;
          state_next       = sts.pend ? S_LAST : S_IDLE;
        end else if (sts.behind) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = lirc_pkg::DIV_PAD;
          state_next    = S_PAD;
        end else begin
          state_next = S_ADV;
        end
      end
      S_QUOT: begin
        if (sts.div_done) begin
          cmd.pend_load = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_PAD: begin
        if (sts.div_done) begin
          cmd.pad_apply = 1'b1;
          state_next    = S_ADV;
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_next  = sts.pend ? S_LAST : S_IDLE;
      end
      S_LAST: begin
        if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n     <= '0;
    end else begin
      state <= state_next;
      if (cmd.load_in) begin
        n <= '0;
      end else if (cmd.pend_load) begin
        n <= n + 1'b1;
      end
    end
  end

  `LIRC_ASSERT_IMP(a_run_cap, 1'b1, n <= NW'(MAX_RUN))
  `LIRC_ASSERT_IMP(a_emit_word, cmd.emit, sts.pend && sts.slot_free)
  `LIRC_ASSERT_IMP(a_div_free, cmd.div_start, !sts.div_busy)
  `LIRC_ASSERT_NXT(a_one_item, in_valid && !in_stall, in_stall)

endmodule

@@ hw/rtl/linear_interp_rate_converter_top.sv @@
// A first word of a block passes straight through; each later interpolated word takes one
// pass of the shared 48-bit divider, which retires two quotient bits per cycle, and
// skipping output positions adds one more division. One input word is processed at a time.
// Synchronous active-high reset: registers 1, totals and counters 0, no block open.
module linear_interp_rate_converter_top #(
  parameter int unsigned MAX_RUN = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lirc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lirc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [lirc_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                  first,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [lirc_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                                  run_last,
  output logic                                  done_res
);

  // The controller sequences each input word: it first divides
  // in_count * in_skip by out_skip to get the block length, then either
  // passes a first word straight through or walks the output positions
  // that fall before the new sample. Every interpolated word needs one
  // division of (next - last) * distance by in_skip; when positions remain
  // after the run is cut short, one more division rounds the output total
  // up to the next output tick at or past the input.
  lirc_pkg::cmd_t cmd;
  lirc_pkg::sts_t sts;

  lirc_ctrl #(
    .MAX_RUN (MAX_RUN)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the configuration registers, the converter state,
  // the divider and a one-word output register. A finished word waits in
  // that register, so the controller keeps working on the next result and
  // only holds when a second word is ready before the first was taken.
  lirc_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_sample  (in_sample),
    .first      (first),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .run_last   (run_last),
    .done_res   (done_res),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
